// ===== rtl/core/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helper functions for the barometer pressure
// compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int unsigned DW = 32;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		CFG_CAL_WORD_0 = 3'd0,
		CFG_CAL_WORD_1 = 3'd1,
		CFG_CAL_WORD_2 = 3'd2,
		CFG_CAL_WORD_3 = 3'd3,
		CFG_CAL_WORD_4 = 3'd4,
		CFG_OSS_MODE   = 3'd5
	} bpc_cfg_idx_t;

	// Compensation constants.
	localparam logic [31:0] B6_OFFSET   = 32'd4000;
	localparam logic [31:0] P_COEF_SQ   = 32'd3038;
	localparam logic [31:0] P_COEF_LIN  = 32'hFFFF_E343; // -7357
	localparam logic [31:0] P_OFFSET    = 32'd3791;
	localparam logic [31:0] B4_OFFSET   = 32'd32768;
	localparam logic [31:0] B7_SCALE    = 32'd50000;
	localparam logic [31:0] T_ROUND     = 32'd8;

	// Working word of one divider step.
	typedef struct packed {
		logic [DW-1:0] num;
		logic [DW-1:0] rem;
		logic [DW-1:0] den;
		logic [DW-1:0] quo;
	} bpc_div_t;

	// Arithmetic right shift of a 32-bit word.
	function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
		asr32 = 32'($signed(v) >>> s);
	endfunction

	// Sign extension of a 16-bit coefficient.
	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

	// Low 32 bits of a product.
	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		mul32 = p[31:0];
	endfunction

endpackage

// ===== rtl/core/bpc_div_cell.sv =====
// ----------------------------------------------------------------------------
// bpc_div_cell
// One restoring division step: resolves one quotient bit and hands the
// working word and its companion data to the next cell.
// ----------------------------------------------------------------------------
module bpc_div_cell #(
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  bpc_pkg::bpc_div_t in_word,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output bpc_pkg::bpc_div_t out_word,
	output logic [SIDE_W-1:0] out_side
);
	import bpc_pkg::*;

	logic [DW:0]   rem_ext;
	logic [DW:0]   diff;
	logic          ge;
	bpc_div_t      nxt;

	// Shift in the next dividend bit and try a subtraction.
	always_comb begin
		rem_ext = {in_word.rem, in_word.num[DW-1]};
		diff    = rem_ext - {1'b0, in_word.den};
		ge      = (rem_ext >= {1'b0, in_word.den});
		nxt.num = {in_word.num[DW-2:0], 1'b0};
		nxt.rem = ge ? diff[DW-1:0] : rem_ext[DW-1:0];
		nxt.den = in_word.den;
		nxt.quo = {in_word.quo[DW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word <= nxt;
			out_side <= in_side;
		end
	end

endmodule

// ===== rtl/core/bpc_div_chain.sv =====
// ----------------------------------------------------------------------------
// bpc_div_chain
// Unsigned 32-bit divider built as a row of division cells, one quotient
// bit per cell, accepting a new operand pair in every enabled cycle.
// ----------------------------------------------------------------------------
module bpc_div_chain #(
	parameter int SIDE_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [bpc_pkg::DW-1:0] in_num,
	input  logic [bpc_pkg::DW-1:0] in_den,
	input  logic [SIDE_W-1:0]      in_side,
	output logic                   out_valid,
	output logic [bpc_pkg::DW-1:0] out_quo,
	output logic [SIDE_W-1:0]      out_side
);
	import bpc_pkg::*;

	logic              vld  [DW+1];
	bpc_div_t          word [DW+1];
	logic [SIDE_W-1:0] side [DW+1];

	// Head of the row: empty remainder and quotient.
	always_comb begin
		vld[0]      = in_valid;
		word[0].num = in_num;
		word[0].rem = '0;
		word[0].den = in_den;
		word[0].quo = '0;
		side[0]     = in_side;
	end

	for (genvar i = 0; i < DW; i++) begin : g_cell
		bpc_div_cell #(.SIDE_W(SIDE_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (vld[i]),
			.in_word  (word[i]),
			.in_side  (side[i]),
			.out_valid(vld[i+1]),
			.out_word (word[i+1]),
			.out_side (side[i+1])
		);
	end

	assign out_valid = vld[DW];
	assign out_quo   = word[DW].quo;
	assign out_side  = side[DW];

endmodule

// ===== rtl/core/barometer_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// barometer_pressure_compensation
// Integer compensation of raw barometer temperature and pressure readings.
// ----------------------------------------------------------------------------
// Usage:
// Load the five calibration words and the oversampling mode through the
// write port while the block is idle. Each transfer on the s_axis side
// carries one raw temperature word and one raw 24-bit pressure reading;
// each transfer on the m_axis side returns the pressure in pascals, the
// temperature in tenths of a degree and a fault flag that is set, with
// both values zero, when a divisor was zero.
// The block takes one item per cycle while the output is not stalled:
// the two 32-step divider rows (temperature term and pressure quotient)
// are pipelined one cell per quotient bit. The whole pipeline advances
// whenever the output register is empty or being read; while the receiver
// stalls a held result, the pipeline freezes and s_axis_tready is low.
// Reset clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module barometer_pressure_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // raw_temperature[15:0], raw_pressure[39:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // pressure_pa[31:0], temperature_deci[63:32],
	                                   // divide_fault[64], zero fill[71:65]
);
	import bpc_pkg::*;

	localparam int SIDE_A = 58;
	localparam int SIDE_B = 34;

	logic [31:0] cal0_q, cal1_q, cal2_q, cal3_q, cal4_q;
	logic [1:0]  oss_q;
	logic        adv;

	// Coefficients.
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sx16(cal0_q[31:16]);
	assign ac2 = sx16(cal0_q[15:0]);
	assign ac3 = sx16(cal1_q[31:16]);
	assign ac4 = {16'd0, cal1_q[15:0]};
	assign ac5 = {16'd0, cal2_q[31:16]};
	assign ac6 = {16'd0, cal2_q[15:0]};
	assign b1  = sx16(cal3_q[31:16]);
	assign b2  = sx16(cal3_q[15:0]);
	assign mc  = sx16(cal4_q[31:16]);
	assign md  = sx16(cal4_q[15:0]);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal0_q <= '0;
			cal1_q <= '0;
			cal2_q <= '0;
			cal3_q <= '0;
			cal4_q <= '0;
			oss_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (bpc_cfg_idx_t'(cfg_index))
				CFG_CAL_WORD_0: cal0_q <= cfg_wdata;
				CFG_CAL_WORD_1: cal1_q <= cfg_wdata;
				CFG_CAL_WORD_2: cal2_q <= cfg_wdata;
				CFG_CAL_WORD_3: cal3_q <= cfg_wdata;
				CFG_CAL_WORD_4: cal4_q <= cfg_wdata;
				CFG_OSS_MODE:   oss_q  <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Global advance: output register empty or being taken.
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// Valid bits of the scalar stages.
	logic v_s1, v_s2, v_a, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_b, v_s9, v_s10, v_s11;

	// Stage 1: temperature product and pressure alignment.
	logic [31:0] x1t_s1;
	logic [23:0] up_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			x1t_s1 <= asr32(mul32({16'd0, s_axis_tdata[15:0]} - ac6, ac5), 5'd15);
			up_s1  <= 24'(s_axis_tdata[39:16] >> (4'd8 - {2'b00, oss_q}));
		end
	end

	// Stage 2: temperature divisor and operand magnitudes.
	logic [31:0] num_s2, den_s2, x1t_s2;
	logic [23:0] up_s2;
	logic        neg_s2, flt_s2;
	logic [31:0] tnum, tden;
	always_comb begin
		tnum = mc << 11;
		tden = x1t_s1 + md;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2 <= tnum[31] ? (32'd0 - tnum) : tnum;
			den_s2 <= tden[31] ? (32'd0 - tden) : tden;
			neg_s2 <= tnum[31] ^ tden[31];
			flt_s2 <= (tden == 32'd0);
			x1t_s2 <= x1t_s1;
			up_s2  <= up_s1;
		end
	end

	// Divider row for the temperature term.
	logic [31:0]       quo_a;
	logic [SIDE_A-1:0] side_a;
	bpc_div_chain #(.SIDE_W(SIDE_A)) u_div_temp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s2),
		.in_num   (num_s2),
		.in_den   (den_s2),
		.in_side  ({x1t_s2, up_s2, neg_s2, flt_s2}),
		.out_valid(v_a),
		.out_quo  (quo_a),
		.out_side (side_a)
	);

	// Stage 3: B5, temperature and B6.
	logic [31:0] x2t, b5;
	logic [31:0] b6_s3, temp_s3;
	logic [23:0] up_s3;
	logic        flt_s3;
	always_comb begin
		x2t = side_a[1] ? (32'd0 - quo_a) : quo_a;
		b5  = side_a[57:26] + x2t;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			b6_s3   <= b5 - B6_OFFSET;
			temp_s3 <= asr32(b5 + T_ROUND, 5'd4);
			up_s3   <= side_a[25:2];
			flt_s3  <= side_a[0];
		end
	end

	// Stage 4: square of B6 and the linear B6 products.
	logic [31:0] sq_s4, pac2_s4, pac3_s4, temp_s4;
	logic [23:0] up_s4;
	logic        flt_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s4   <= asr32(mul32(b6_s3, b6_s3), 5'd12);
			pac2_s4 <= asr32(mul32(ac2, b6_s3), 5'd11);
			pac3_s4 <= asr32(mul32(ac3, b6_s3), 5'd13);
			temp_s4 <= temp_s3;
			up_s4   <= up_s3;
			flt_s4  <= flt_s3;
		end
	end

	// Stage 5: products with the square.
	logic [31:0] pb2_s5, pb1_s5, pac2_s5, pac3_s5, temp_s5;
	logic [23:0] up_s5;
	logic        flt_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			pb2_s5  <= asr32(mul32(b2, sq_s4), 5'd11);
			pb1_s5  <= asr32(mul32(b1, sq_s4), 5'd16);
			pac2_s5 <= pac2_s4;
			pac3_s5 <= pac3_s4;
			temp_s5 <= temp_s4;
			up_s5   <= up_s4;
			flt_s5  <= flt_s4;
		end
	end

	// Stage 6: B3 and the B4 operand.
	logic [31:0] b3v, b3r;
	logic [31:0] b3_s6, x3_s6, temp_s6;
	logic [23:0] up_s6;
	logic        flt_s6;
	always_comb begin
		b3v = (((ac1 << 2) + pb2_s5 + pac2_s5) << oss_q) + 32'd2;
		// Signed division by four, truncating toward zero.
		b3r = asr32(b3v + (b3v[31] ? 32'd3 : 32'd0), 5'd2);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			b3_s6   <= b3r;
			x3_s6   <= asr32(pac3_s5 + pb1_s5 + 32'd2, 5'd2);
			temp_s6 <= temp_s5;
			up_s6   <= up_s5;
			flt_s6  <= flt_s5;
		end
	end

	// Stage 7: B4 and the B7 operand.
	logic [31:0] b4m;
	logic [31:0] b4_s7, d7_s7, temp_s7;
	logic        flt_s7;
	assign b4m = mul32(ac4, x3_s6 + B4_OFFSET);
	always_ff @(posedge clk) begin
		if (adv) begin
			b4_s7   <= b4m >> 15;
			d7_s7   <= {8'd0, up_s6} - b3_s6;
			temp_s7 <= temp_s6;
			flt_s7  <= flt_s6;
		end
	end

	// Stage 8: B7 and the pressure divisor check.
	logic [31:0] b7_s8, b4_s8, temp_s8;
	logic        flt_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			b7_s8   <= mul32(d7_s7, B7_SCALE >> oss_q);
			b4_s8   <= b4_s7;
			temp_s8 <= temp_s7;
			flt_s8  <= flt_s7 || (b4_s7 == 32'd0);
		end
	end

	// Divider row for the pressure quotient.
	logic [31:0]       quo_b;
	logic [SIDE_B-1:0] side_b;
	bpc_div_chain #(.SIDE_W(SIDE_B)) u_div_pres (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s8),
		.in_num   (b7_s8[31] ? b7_s8 : (b7_s8 << 1)),
		.in_den   (b4_s8),
		.in_side  ({temp_s8, b7_s8[31], flt_s8}),
		.out_valid(v_b),
		.out_quo  (quo_b),
		.out_side (side_b)
	);

	// Stage 9: raw pressure.
	logic [31:0] p_s9, temp_s9;
	logic        flt_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s9    <= side_b[1] ? (quo_b << 1) : quo_b;
			temp_s9 <= side_b[33:2];
			flt_s9  <= side_b[0];
		end
	end

	// Stage 10: correction products.
	logic [31:0] x1p;
	logic [31:0] sqp_s10, x2p_s10, p_s10, temp_s10;
	logic        flt_s10;
	assign x1p = asr32(p_s9, 5'd8);
	always_ff @(posedge clk) begin
		if (adv) begin
			sqp_s10  <= mul32(x1p, x1p);
			x2p_s10  <= asr32(mul32(P_COEF_LIN, p_s9), 5'd16);
			p_s10    <= p_s9;
			temp_s10 <= temp_s9;
			flt_s10  <= flt_s9;
		end
	end

	// Stage 11: scaled square term.
	logic [31:0] x1p_s11, x2p_s11, p_s11, temp_s11;
	logic        flt_s11;
	always_ff @(posedge clk) begin
		if (adv) begin
			x1p_s11  <= asr32(mul32(sqp_s10, P_COEF_SQ), 5'd16);
			x2p_s11  <= x2p_s10;
			p_s11    <= p_s10;
			temp_s11 <= temp_s10;
			flt_s11  <= flt_s10;
		end
	end

	// Output register: final pressure, zeroed on a divide fault.
	logic [31:0] p_fin;
	assign p_fin = p_s11 + asr32(x1p_s11 + x2p_s11 + P_OFFSET, 5'd4);
	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= flt_s11 ? {7'd0, 1'b1, 64'd0}
			                        : {7'd0, 1'b0, temp_s11, p_fin};
		end
	end

	// Valid bits of the scalar stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			v_s5          <= 1'b0;
			v_s6          <= 1'b0;
			v_s7          <= 1'b0;
			v_s8          <= 1'b0;
			v_s9          <= 1'b0;
			v_s10         <= 1'b0;
			v_s11         <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1          <= s_axis_tvalid;
			v_s2          <= v_s1;
			v_s3          <= v_a;
			v_s4          <= v_s3;
			v_s5          <= v_s4;
			v_s6          <= v_s5;
			v_s7          <= v_s6;
			v_s8          <= v_s7;
			v_s9          <= v_b;
			v_s10         <= v_s9;
			v_s11         <= v_s10;
			m_axis_tvalid <= v_s11;
		end
	end

endmodule

// ===== rtl/core/bpc_checker.sv =====
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks on the barometer pressure compensation block.
// ----------------------------------------------------------------------------
module bpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata
);

	// A faulted result carries zero pressure and temperature.
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tdata[63:0] == 64'd0)
		else $error("divide fault with nonzero result");

	// A stalled result is held until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// The input side stops while a result is stalled.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

	// The fill bits above the fault flag stay zero.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[71:65] == 7'd0)
		else $error("nonzero fill bits");

endmodule

bind barometer_pressure_compensation bpc_checker u_bpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

// ===== tb/barometer_pressure_compensation_tb.sv =====
// ----------------------------------------------------------------------------
// barometer_pressure_compensation_tb
// Self-checking bench for the barometer compensation block. Raw temperature
// and pressure pairs are streamed in under several calibration settings and
// every oversampling mode. An in-bench predictor computes each expected
// result, and a scoreboard compares the results in order, field by field.
// ----------------------------------------------------------------------------
module barometer_pressure_compensation_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bpc_pkg::*;

	typedef struct packed {
		logic        fault;
		logic [31:0] temp_deci;
		logic [31:0] press_pa;
	} comp_result_t;

	// Holds the predicted results and checks the block's results against them.
	class comp_scoreboard;
		logic [31:0] cal [5];
		logic [1:0]  oss;
		comp_result_t pending [$];
		int          mismatches;
		int          results_seen;

		function void set_reg(bpc_cfg_idx_t idx, logic [31:0] v);
			if (idx == CFG_OSS_MODE)
				oss = v[1:0];
			else
				cal[idx] = v;
		endfunction

		// Arithmetic shift right and signed truncating division, 32-bit.
		function logic [31:0] sar(logic [31:0] v, int s);
			return 32'($signed(v) >>> s);
		endfunction

		function logic [31:0] sdiv(logic [31:0] n, logic [31:0] d);
			return 32'($signed(n) / $signed(d));
		endfunction

		function comp_result_t compensate(logic [15:0] ut, logic [23:0] raw_p);
			logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
			logic [31:0] up, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, t;
			logic [63:0] prod;
			comp_result_t r;
			ac1 = {{16{cal[0][31]}}, cal[0][31:16]};
			ac2 = {{16{cal[0][15]}}, cal[0][15:0]};
			ac3 = {{16{cal[1][31]}}, cal[1][31:16]};
			ac4 = {16'd0, cal[1][15:0]};
			ac5 = {16'd0, cal[2][31:16]};
			ac6 = {16'd0, cal[2][15:0]};
			b1  = {{16{cal[3][31]}}, cal[3][31:16]};
			b2  = {{16{cal[3][15]}}, cal[3][15:0]};
			mc  = {{16{cal[4][31]}}, cal[4][31:16]};
			md  = {{16{cal[4][15]}}, cal[4][15:0]};
			up  = {8'd0, raw_p} >> (8 - oss);
			r = '0;
			r.fault = 1'b1;
			x1 = sar(32'(({16'd0, ut} - ac6) * ac5), 15);
			den = x1 + md;
			if (den == 0)
				return r;
			x2 = sdiv(mc << 11, den);
			b5 = x1 + x2;
			t = sar(b5 + 32'd8, 4);
			b6 = b5 - 32'd4000;
			sq = sar(32'(b6 * b6), 12);
			x1 = sar(32'(b2 * sq), 11);
			x2 = sar(32'(ac2 * b6), 11);
			x3 = x1 + x2;
			b3 = sdiv(((32'(ac1 * 32'd4) + x3) << oss) + 32'd2, 32'd4);
			x1 = sar(32'(ac3 * b6), 13);
			x2 = sar(32'(b1 * sq), 16);
			x3 = sar(x1 + x2 + 32'd2, 2);
			b4 = 32'(ac4 * (x3 + 32'd32768)) >> 15;
			b7 = 32'((up - b3) * (32'd50000 >> oss));
			if (b4 == 0)
				return r;
			if (b7 < 32'h8000_0000)
				p = (b7 * 32'd2) / b4;
			else
				p = (b7 / b4) * 32'd2;
			x1 = sar(p, 8);
			x1 = 32'(x1 * x1);
			x1 = sar(32'(x1 * 32'd3038), 16);
			prod = 64'(32'hFFFF_E343) * 64'(p);
			x2 = sar(prod[31:0], 16);
			p = p + sar(x1 + x2 + 32'd3791, 4);
			r.press_pa = p;
			r.temp_deci = t;
			r.fault = 1'b0;
			return r;
		endfunction

		function void note_sample(logic [39:0] data);
			pending.push_back(compensate(data[15:0], data[39:16]));
		endfunction

		function void check_result(logic [71:0] data);
			comp_result_t got, want;
			got = data[64:0];
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %h", data);
				return;
			end
			want = pending.pop_front();
			if (got.press_pa !== want.press_pa || got.temp_deci !== want.temp_deci ||
					got.fault !== want.fault || data[71:65] !== 7'd0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d expected p=%0d t=%0d f=%b, got p=%0d t=%0d f=%b",
						results_seen, $signed(want.press_pa), $signed(want.temp_deci),
						want.fault, $signed(got.press_pa), $signed(got.temp_deci), got.fault);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;  // raw_temperature[15:0], raw_pressure[39:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;  // pressure_pa[31:0], temperature_deci[63:32],
	                            // divide_fault[64], zero fill[71:65]

	comp_scoreboard sb;
	int  cycle_count;
	bit  hold_off;
	int  samples_sent;

	localparam int PIPE_LATENCY = 76;
	localparam int CYCLE_LIMIT  = 400000;

	barometer_pressure_compensation dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Cycle counter with a hard limit on the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Monitor: note input transfers and check output transfers.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_sample(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			n = $urandom_range(0, 9);
			if (n < 6)
				m_axis_tready <= 1'b1;
			else if (n < 9) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end
		end
	end

	task automatic write_reg(bpc_cfg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// Offer one sample and hold it until the transfer, with an optional random gap first.
	task automatic send_sample(logic [15:0] ut, logic [23:0] up, bit gaps);
		int n;
		n = $urandom_range(0, 19);
		if (gaps && n >= 12) begin
			s_axis_tvalid <= 1'b0;
			repeat ((n == 19) ? $urandom_range(10, 30) : $urandom_range(1, 3))
				@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {up, ut};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		samples_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (PIPE_LATENCY + 10) @(negedge clk);
	endtask

	// Calibration close to a real part's values.
	task automatic load_typical(logic [1:0] mode);
		write_reg(CFG_CAL_WORD_0, {16'd408, 16'hFFB8});
		write_reg(CFG_CAL_WORD_1, {16'hC6D1, 16'd32741});
		write_reg(CFG_CAL_WORD_2, {16'd32757, 16'd23153});
		write_reg(CFG_CAL_WORD_3, {16'd6190, 16'd4});
		write_reg(CFG_CAL_WORD_4, {16'hD4BD, 16'd2868});
		write_reg(CFG_OSS_MODE, {30'd0, mode});
	endtask

	function automatic logic [15:0] near(int base, int span);
		return 16'(base + $signed($urandom_range(0, 2 * span)) - span);
	endfunction

	initial begin
		logic [31:0] rv;
		sb = new();
		cycle_count = 0;
		hold_off = 1'b0;
		samples_sent = 0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		sb.oss = '0;
		foreach (sb.cal[i]) sb.cal[i] = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values: all coefficients zero, so every divisor is zero.
		send_sample(16'h0000, 24'h000000, 0);
		send_sample(16'hFFFF, 24'hFFFFFF, 0);
		drain();

		// Directed items with typical calibration at each extreme of the fields.
		load_typical(2'd0);
		send_sample(16'd27898, 24'h5D23E0, 0);
		send_sample(16'h0000, 24'h000000, 0);
		send_sample(16'hFFFF, 24'hFFFFFF, 0);
		send_sample(16'h8000, 24'h800000, 0);
		send_sample(16'h7FFF, 24'h7FFFFF, 0);
		drain();
		write_reg(CFG_OSS_MODE, 32'd3);
		send_sample(16'd27898, 24'h5D23E0, 0);
		send_sample(16'hFFFF, 24'hFFFFFF, 0);
		send_sample(16'h0000, 24'h000000, 0);
		drain();

		// Temperature divisor zero: AC5 = 0 makes X1 zero, MD = 0.
		write_reg(CFG_CAL_WORD_2, {16'd0, 16'd100});
		write_reg(CFG_CAL_WORD_4, {16'h8000, 16'd0});
		send_sample(16'd1234, 24'h123456, 0);
		drain();
		// Pressure divisor zero: AC4 = 0.
		load_typical(2'd1);
		write_reg(CFG_CAL_WORD_1, {16'h8000, 16'd0});
		send_sample(16'd27898, 24'h5D23E0, 0);
		drain();
		// Extreme coefficients with the negative B7 dividend path.
		write_reg(CFG_CAL_WORD_0, 32'h7FFF_8000);
		write_reg(CFG_CAL_WORD_1, 32'h7FFF_FFFF);
		write_reg(CFG_CAL_WORD_2, 32'hFFFF_FFFF);
		write_reg(CFG_CAL_WORD_3, 32'h8000_7FFF);
		write_reg(CFG_CAL_WORD_4, 32'h7FFF_8000);
		send_sample(16'h0000, 24'h000000, 0);
		send_sample(16'hFFFF, 24'hFFFFFF, 0);
		send_sample(16'h5555, 24'hAAAAAA, 0);
		drain();
		// A write to an index beyond the registers is ignored.
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= 3'd7;
		cfg_wdata <= 32'hFFFF_FFFF;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		send_sample(16'h1234, 24'h654321, 0);
		drain();

		// Random phases: mostly realistic calibration, some fully random.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph % 4 == 3) begin
				for (int r = 0; r < 5; r++) begin
					rv = $urandom();
					write_reg(bpc_cfg_idx_t'(r), rv);
				end
				write_reg(CFG_OSS_MODE, 32'($urandom_range(0, 3)));
			end else
				load_typical(2'(ph));
			if (ph == 2)
				hold_off = 1'b1;
			for (int i = 0; i < 230; i++) begin
				if (ph % 4 != 3 && i % 8 != 0)
					send_sample(near(27898, 6000), 24'($urandom()), 1);
				else
					send_sample(16'($urandom()), 24'($urandom()), 1);
			end
			drain();
		end

		$display("Sent %0d samples over all four oversampling modes, %0d results checked.",
			samples_sent, sb.results_seen);
		$display("Covered zero divisors, extreme coefficients and a long output stall.");
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/bpc_pkg.sv
rtl/core/bpc_div_cell.sv
rtl/core/bpc_div_chain.sv
rtl/core/barometer_pressure_compensation.sv
rtl/core/bpc_checker.sv
tb/barometer_pressure_compensation_tb.sv
